FILE: rtl/mrsc_pkg.sv
// ============================================================================
// mrsc_pkg
// Shared types, sizing constants and helpers of the ring staging controller.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mrsc_pkg;

    // Ring and flash geometry
    localparam int RING_BYTES      = 40960;
    localparam int PAGE_BYTES      = 8192;
    localparam int PAGES_PER_BLOCK = 128;
    localparam int BLOCK_COUNT     = 1024;
    localparam int CHANNELS        = 4;

    // Fixed field widths
    localparam int NUM_BASES = 4;
    localparam int ADDR_W    = 17;
    localparam int CNT_W     = 16;
    localparam int FILL_W    = 16;
    localparam int CH_W      = 2;
    localparam int OBLK_W    = 10;
    localparam int OPG_W     = 7;

    // Derived state widths
    localparam int OFS_W = $clog2(RING_BYTES);
    localparam int PG_W  = $clog2(PAGES_PER_BLOCK);
    localparam int BLK_W = $clog2(BLOCK_COUNT + 1);
    // Wide enough for twice the largest ring, a full count or a page
    localparam int SUM_W = 18;

    // Operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DRAIN   = 1'b1;

    // Register map
    localparam logic [1:0] REG_BASE0 = 2'd0;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_RING_FULL  = 2'd1,
        ST_SHORT      = 2'd2,
        ST_FLASH_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic              operation;
        logic [CH_W-1:0]   channel;
        logic [CNT_W-1:0]  byte_count;
    } t_request;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] memory_address;
        logic [CH_W-1:0]   flash_zone;
        logic [OBLK_W-1:0] flash_block;
        logic [OPG_W-1:0]  flash_page;
        logic [FILL_W-1:0] fill_level;
        logic              flash_has_data;
    } t_result;

    typedef logic [NUM_BASES-1:0][ADDR_W-1:0] t_base_arr;

    // Fold a channel number into the configured channel count
    function automatic logic [CH_W-1:0] map_channel(input logic [CH_W-1:0] v);
        logic [CH_W:0] acc;
        acc = {1'b0, v};
        for (int k = 0; k < 3; k++) begin
            if (acc >= (CH_W+1)'(CHANNELS)) begin
                acc = acc - (CH_W+1)'(CHANNELS);
            end
        end
        return acc[CH_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mrsc_regs.sv
// ============================================================================
// mrsc_regs
// APB register file holding the staging base address of each channel ring.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mrsc_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output mrsc_pkg::t_base_arr    o_bases
);
    import mrsc_pkg::*;

    t_base_arr  r_bases;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Load base registers on a completed write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bases[0] <= ADDR_W'(0);
            r_bases[1] <= ADDR_W'(32'h0A000);
            r_bases[2] <= ADDR_W'(32'h14000);
            r_bases[3] <= ADDR_W'(32'h1E000);
        end else if (wr_en) begin
            r_bases[reg_idx - REG_BASE0] <= pwdata[ADDR_W-1:0];
        end
    end

    // Return the addressed base on reads
    assign prdata  = {{(32-ADDR_W){1'b0}}, r_bases[reg_idx - REG_BASE0]};
    assign o_bases = r_bases;

endmodule

`default_nettype wire

FILE: rtl/mrsc_ring.sv
// ============================================================================
// mrsc_ring
// Per-channel ring pointers and flash page counters; one request per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mrsc_ring (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_vld,
    input  wire mrsc_pkg::t_request  i_req,
    input  wire mrsc_pkg::t_base_arr i_bases,
    output logic                     o_done,
    output mrsc_pkg::t_result        o_result
);
    import mrsc_pkg::*;

    logic [NUM_BASES-1:0][OFS_W-1:0] r_wo;
    logic [NUM_BASES-1:0][OFS_W-1:0] r_ro;
    logic [NUM_BASES-1:0][PG_W-1:0]  r_pg;
    logic [NUM_BASES-1:0][BLK_W-1:0] r_blk;
    logic [NUM_BASES-1:0]            r_wr;
    logic                            r_done;
    t_result                         r_result;

    logic [CH_W-1:0]  ch;
    logic [OFS_W-1:0] wo, ro, fill;
    logic [SUM_W-1:0] fill_sum, enq_sum, wo_sum, ro_sum;
    logic [OFS_W-1:0] n_wo, n_ro;
    logic [PG_W:0]    pg_inc;
    logic [PG_W-1:0]  n_pg;
    logic [BLK_W-1:0] n_blk;
    logic             do_enq, do_drain;
    t_result          n_result;

    // Select the channel and its current pointers
    assign ch = map_channel(i_req.channel);
    assign wo = r_wo[ch];
    assign ro = r_ro[ch];

    // Fill level: (wo - ro) mod ring by a single corrective subtract
    assign fill_sum = SUM_W'(wo) + SUM_W'(RING_BYTES) - SUM_W'(ro);
    assign fill     = (fill_sum >= SUM_W'(RING_BYTES))
                      ? OFS_W'(fill_sum - SUM_W'(RING_BYTES)) : OFS_W'(fill_sum);

    // Advanced pointers, wrapped at the ring size
    assign enq_sum = SUM_W'(fill) + SUM_W'(i_req.byte_count);
    assign wo_sum  = SUM_W'(wo) + SUM_W'(i_req.byte_count);
    assign n_wo    = (wo_sum >= SUM_W'(RING_BYTES))
                     ? OFS_W'(wo_sum - SUM_W'(RING_BYTES)) : OFS_W'(wo_sum);
    assign ro_sum  = SUM_W'(ro) + SUM_W'(PAGE_BYTES);
    assign n_ro    = (ro_sum >= SUM_W'(RING_BYTES))
                     ? OFS_W'(ro_sum - SUM_W'(RING_BYTES)) : OFS_W'(ro_sum);

    // Step the page, carry into the block
    assign pg_inc = (PG_W+1)'(r_pg[ch]) + (PG_W+1)'(1);
    assign n_pg   = (pg_inc >= (PG_W+1)'(PAGES_PER_BLOCK)) ? PG_W'(0) : pg_inc[PG_W-1:0];
    assign n_blk  = (pg_inc >= (PG_W+1)'(PAGES_PER_BLOCK))
                    ? r_blk[ch] + BLK_W'(1) : r_blk[ch];

    // Decide the outcome and build the result
    always_comb begin
        n_result                = '0;
        n_result.status         = ST_DONE;
        n_result.fill_level     = FILL_W'(fill);
        n_result.flash_has_data = r_wr[ch];
        do_enq                  = 1'b0;
        do_drain                = 1'b0;
        if (i_req.operation == OP_ENQUEUE) begin
            if (enq_sum >= SUM_W'(RING_BYTES)) begin
                n_result.status = ST_RING_FULL;
            end else begin
                do_enq                  = 1'b1;
                n_result.memory_address = i_bases[ch] + ADDR_W'(wo);
                n_result.fill_level     = FILL_W'(enq_sum);
            end
        end else begin
            if (fill < OFS_W'(PAGE_BYTES) || SUM_W'(PAGE_BYTES) >= SUM_W'(RING_BYTES)) begin
                n_result.status = ST_SHORT;
            end else if (r_blk[ch] >= BLK_W'(BLOCK_COUNT)) begin
                n_result.status = ST_FLASH_FULL;
            end else begin
                do_drain                = 1'b1;
                n_result.memory_address = i_bases[ch] + ADDR_W'(ro);
                n_result.flash_zone     = ch;
                n_result.flash_block    = OBLK_W'(r_blk[ch]);
                n_result.flash_page     = OPG_W'(r_pg[ch]);
                n_result.fill_level     = FILL_W'(fill - OFS_W'(PAGE_BYTES));
                n_result.flash_has_data = 1'b1;
            end
        end
    end

    // Commit pointer and counter updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wo  <= '0;
            r_ro  <= '0;
            r_pg  <= '0;
            r_blk <= '0;
            r_wr  <= '0;
        end else if (i_vld) begin
            if (do_enq) begin
                r_wo[ch] <= n_wo;
            end
            if (do_drain) begin
                r_ro[ch]  <= n_ro;
                r_pg[ch]  <= n_pg;
                r_blk[ch] <= n_blk;
                r_wr[ch]  <= 1'b1;
            end
        end
    end

    // Register the result and its strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: rtl/multichannel_ring_staging_controller.sv
// ============================================================================
// multichannel_ring_staging_controller
// Ring pointer and flash page manager for four staging channels.
// ============================================================================
// Usage:
//   Request channel: drive i_req (operation, channel, byte_count) with
//   i_start high; the transaction is taken at any edge where o_busy is low.
//   o_busy is never asserted, so one request can be issued every cycle.
//   Result channel: o_done pulses for one cycle with o_result valid. The
//   receiver must take it in that cycle; it cannot stall the block.
//   Path: request register, then result register, from the accepting
//   edge to o_done; throughput one request per cycle, set by the single
//   compare-and-subtract pass over the selected channel's pointers.
//   Back-to-back requests to the same channel see the prior update.
//   Configuration: APB registers at byte offsets 0, 4, 8, 12 hold each
//   channel's staging base address; write them only while idle.
//   Reset: pointers, page and block counters and written flags clear,
//   bases return to 0x0, 0xA000, 0x14000 and 0x1E000; no clearing pass.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module multichannel_ring_staging_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire mrsc_pkg::t_request i_req,
    output logic                    o_done,
    output mrsc_pkg::t_result       o_result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    import mrsc_pkg::*;

    t_request  r_req;
    logic      r_req_vld;
    t_base_arr bases;

    assign o_busy = 1'b0;

    // Capture each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_req <= i_req;
        end
    end

    mrsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_bases (bases)
    );

    mrsc_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_req_vld),
        .i_req    (r_req),
        .i_bases  (bases),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the ring staging controller. A driver feeds
// enqueue and drain requests from a backlog with random gaps, a predictor
// tracks each channel's ring offsets and flash page counter, and a monitor
// compares every result strobe field by field. Base registers are
// rewritten over APB between phases while the block is idle, and one
// channel is drained below a page, refilled and drained again.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    import mrsc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 6;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    t_request          i_req;
    logic              o_done;
    t_result           o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Predictor copy of the per-channel state and the base registers
    logic [ADDR_W-1:0] base_reg  [NUM_BASES] = '{17'h0, 17'hA000, 17'h14000, 17'h1E000};
    logic [15:0]       wr_ofs    [CHANNELS]  = '{default: '0};
    logic [15:0]       rd_ofs    [CHANNELS]  = '{default: '0};
    logic [PG_W-1:0]   page_cnt  [CHANNELS]  = '{default: '0};
    logic [BLK_W-1:0]  blk_cnt   [CHANNELS]  = '{default: '0};
    logic              written   [CHANNELS]  = '{default: 1'b0};

    t_request          requests_waiting [$];
    t_result           ring_results_due [$];
    int                gap_pct = 0;
    bit                req_taken = 1'b0;
    int                err_count = 0;
    int                cycle_count = 0;

    multichannel_ring_staging_controller u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Toggle the clock
    always #6 i_clk = ~i_clk;

    // Bytes queued in a channel ring
    function automatic int unsigned ring_fill(input int unsigned ch);
        return (int'(wr_ofs[ch]) + RING_BYTES - int'(rd_ofs[ch])) % RING_BYTES;
    endfunction

    // Apply one request to the predicted state and return its result
    function automatic t_result advance_ring(input t_request req);
        t_result     res;
        int unsigned ch;
        int unsigned cnt;
        int unsigned fill;
        res = '0;
        res.status = ST_DONE;
        ch = int'(req.channel) % CHANNELS;
        cnt = int'(req.byte_count);
        fill = ring_fill(ch);
        if (req.operation == OP_ENQUEUE) begin
            if (fill + cnt >= RING_BYTES) begin
                res.status = ST_RING_FULL;
            end else begin
                res.memory_address = ADDR_W'(int'(base_reg[ch]) + int'(wr_ofs[ch]));
                wr_ofs[ch] = 16'((int'(wr_ofs[ch]) + cnt) % RING_BYTES);
            end
        end else if (fill < PAGE_BYTES) begin
            res.status = ST_SHORT;
        end else if (int'(blk_cnt[ch]) >= BLOCK_COUNT) begin
            res.status = ST_FLASH_FULL;
        end else begin
            res.memory_address = ADDR_W'(int'(base_reg[ch]) + int'(rd_ofs[ch]));
            res.flash_zone = CH_W'(ch);
            res.flash_block = OBLK_W'(blk_cnt[ch]);
            res.flash_page = OPG_W'(page_cnt[ch]);
            // Step the page, carry into the block at the end of a block
            if (int'(page_cnt[ch]) + 1 >= PAGES_PER_BLOCK) begin
                page_cnt[ch] = '0;
                blk_cnt[ch] = blk_cnt[ch] + 1'b1;
            end else begin
                page_cnt[ch] = page_cnt[ch] + 1'b1;
            end
            written[ch] = 1'b1;
            rd_ofs[ch] = 16'((int'(rd_ofs[ch]) + PAGE_BYTES) % RING_BYTES);
        end
        res.fill_level = FILL_W'(ring_fill(ch));
        res.flash_has_data = written[ch];
        return res;
    endfunction

    // Record accepted transactions and predict their results
    always @(posedge i_clk) begin : accept_blk
        req_taken = i_rst_n && i_start && !o_busy;
        if (req_taken) begin
            ring_results_due.push_back(advance_ring(i_req));
        end
    end

    // Drive the next request on the falling edge once the last one was taken
    always @(negedge i_clk) begin : drive_blk
        t_request next_req;
        logic     next_start;
        next_req = i_req;
        next_start = i_start;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else if (!i_start || req_taken) begin
            next_start = 1'b0;
            next_req = t_request'($urandom);
            if (requests_waiting.size() > 0 && $urandom_range(99) >= gap_pct) begin
                next_req = requests_waiting.pop_front();
                next_start = 1'b1;
            end
        end
        i_start <= next_start;
        i_req <= next_req;
    end

    // Compare each result strobe with the oldest prediction
    always @(posedge i_clk) begin : check_blk
        t_result want;
        if (i_rst_n && o_done) begin
            if (ring_results_due.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                err_count++;
            end else begin
                want = ring_results_due.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_result.status);
                    err_count++;
                end
                if (o_result.memory_address !== want.memory_address) begin
                    $error("memory_address: expected 0x%0h, actual 0x%0h",
                           want.memory_address, o_result.memory_address);
                    err_count++;
                end
                if (o_result.flash_zone !== want.flash_zone) begin
                    $error("flash_zone: expected %0d, actual %0d",
                           want.flash_zone, o_result.flash_zone);
                    err_count++;
                end
                if (o_result.flash_block !== want.flash_block) begin
                    $error("flash_block: expected %0d, actual %0d",
                           want.flash_block, o_result.flash_block);
                    err_count++;
                end
                if (o_result.flash_page !== want.flash_page) begin
                    $error("flash_page: expected %0d, actual %0d",
                           want.flash_page, o_result.flash_page);
                    err_count++;
                end
                if (o_result.fill_level !== want.fill_level) begin
                    $error("fill_level: expected %0d, actual %0d",
                           want.fill_level, o_result.fill_level);
                    err_count++;
                end
                if (o_result.flash_has_data !== want.flash_has_data) begin
                    $error("flash_has_data: expected %0d, actual %0d",
                           want.flash_has_data, o_result.flash_has_data);
                    err_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin : watchdog_blk
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_request(input logic op, input int ch, input int cnt);
        t_request req;
        req.operation = op;
        req.channel = CH_W'(ch);
        req.byte_count = CNT_W'(cnt);
        requests_waiting.push_back(req);
    endtask

    // Mix of drains and enqueues of assorted sizes on random channels
    task automatic add_random_requests(input int n);
        int sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(19);
            if (sel < 9) begin
                add_request(OP_DRAIN, $urandom_range(3), $urandom_range(65535));
            end else if (sel == 9) begin
                add_request(OP_ENQUEUE, $urandom_range(3), 0);
            end else if (sel < 12) begin
                add_request(OP_ENQUEUE, $urandom_range(3), $urandom_range(65535));
            end else if (sel == 12) begin
                add_request(OP_ENQUEUE, $urandom_range(3), $urandom_range(40959, 30000));
            end else begin
                add_request(OP_ENQUEUE, $urandom_range(3), $urandom_range(9000));
            end
        end
    endtask

    // Write one base register over APB, then read it back
    task automatic write_base(input int idx, input logic [ADDR_W-1:0] val);
        logic [31:0] seen;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {2'(REG_BASE0 + 2'(idx)), 2'b00};
        pwdata <= 32'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        base_reg[idx] = val;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        seen = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (seen[ADDR_W-1:0] !== val) begin
            $error("base_channel%0d: expected 0x%0h, actual 0x%0h", idx, val, seen[ADDR_W-1:0]);
            err_count++;
        end
    endtask

    // Wait until every transaction is taken and every result has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (requests_waiting.size() != 0 || i_start || ring_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus_blk
        int drain_ch;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Phase one: reset bases, directed corner cases, then random traffic
        gap_pct = 37;
        add_request(OP_ENQUEUE, 0, 0);          // zero-byte enqueue
        add_request(OP_ENQUEUE, 0, 65535);      // oversized, refused
        add_request(OP_DRAIN,   0, 0);          // empty ring, short
        add_request(OP_ENQUEUE, 1, 40959);      // fill to the last free slot
        add_request(OP_ENQUEUE, 1, 0);          // zero bytes into a full ring
        add_request(OP_ENQUEUE, 1, 1);          // full ring refused
        repeat (5) add_request(OP_DRAIN, 1, 65535);  // four pages, then short
        add_request(OP_ENQUEUE, 3, 40960);      // exactly the ring size, refused
        add_request(OP_ENQUEUE, 3, 40000);
        add_request(OP_ENQUEUE, 3, 959);
        add_request(OP_DRAIN,   3, 0);
        add_request(OP_ENQUEUE, 3, 100);        // write offset wraps
        add_request(OP_DRAIN,   3, 0);          // address wraps past 17 bits
        add_request(OP_ENQUEUE, 2, 32768);
        add_request(OP_ENQUEUE, 2, 8191);
        add_request(OP_DRAIN,   2, 0);
        add_request(OP_DRAIN,   2, 0);
        add_request(OP_ENQUEUE, 1, 32768);
        add_request(OP_DRAIN,   1, 0);
        add_random_requests(600);
        wait_idle();

        // Phase two: extreme bases, slow sender
        write_base(0, 17'h1FFFF);
        write_base(1, 17'h0);
        write_base(2, 17'h1F000);
        write_base(3, ADDR_W'($urandom_range(131071)));
        gap_pct = 70;
        add_random_requests(600);
        wait_idle();

        // Phase three: new bases, no gaps, one channel drained and refilled
        write_base(0, 17'h0);
        write_base(1, 17'h1FFFF);
        write_base(2, ADDR_W'($urandom_range(131071)));
        write_base(3, ADDR_W'($urandom_range(131071)));
        gap_pct = 0;
        drain_ch = $urandom_range(3);
        // Drop the ring below one page, then refill two pages and drain past them
        repeat (5) add_request(OP_DRAIN, drain_ch, 0);
        add_request(OP_ENQUEUE, drain_ch, 2 * PAGE_BYTES);
        repeat (3) add_request(OP_DRAIN, drain_ch, $urandom_range(65535));
        add_random_requests(620);
        wait_idle();

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/mrsc_pkg.sv
rtl/mrsc_regs.sv
rtl/mrsc_ring.sv
rtl/multichannel_ring_staging_controller.sv
tb/testbench.sv
